// File: hw/rtl/e2c_pkg.sv
// shared widths, latencies and beat structs for the epoch to calendar converter
package e2c_pkg;

    localparam int unsigned EPOCH_W = 40;
    localparam int unsigned YEAR_W  = 16;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned SEC_W   = 6;
    localparam int unsigned WDAY_W  = 3;

    localparam int unsigned DAYS_W  = 24;
    localparam int unsigned SOD_W   = 17;

    localparam int unsigned DSP_LAT = 4;
    localparam int unsigned CLK_LAT = 4;
    localparam int unsigned CIV_LAT = 10;
    localparam int unsigned E2C_LAT = DSP_LAT + CIV_LAT;

    typedef struct packed {
        logic [DAYS_W-1:0] days;
        logic [SOD_W-1:0]  sod;
    } day_split_t;

    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
        logic [WDAY_W-1:0] weekday;
    } tod_t;

    typedef struct packed {
        logic signed [YEAR_W-1:0] year;
        logic [MONTH_W-1:0]       month;
        logic [DAY_W-1:0]         day;
    } date_t;

endpackage

// File: hw/rtl/e2c_day_split.sv
// four-stage split of epoch seconds into a biased day count and second of day
module e2c_day_split
    import e2c_pkg::*;
(
    input  logic                      clk,
    input  logic signed [EPOCH_W-1:0] epoch_seconds,
    output day_split_t                split
);

    localparam logic [33:0] DAY_BIAS = 34'd4294968300;
    localparam logic [24:0] RECIP    = 25'd25451658;
    localparam logic [9:0]  DIV_675  = 10'd675;

    logic [33:0] v1_next;
    logic [33:0] v1_reg;
    logic [6:0]  lo1_reg;

    logic [48:0] qprod;
    logic [23:0] qe2_next;
    logic [23:0] qe2_reg;
    logic [33:0] v2_reg;
    logic [6:0]  lo2_reg;

    logic [33:0] rest;
    logic [11:0] re3_next;
    logic [11:0] re3_reg;
    logic [23:0] qe3_reg;
    logic [6:0]  lo3_reg;

    logic [11:0] rfix;
    logic [23:0] qfix;
    day_split_t  split_next;
    day_split_t  split_reg;

    // floor by 128 then bias so the day count never goes negative
    assign v1_next = {epoch_seconds[EPOCH_W-1], epoch_seconds[EPOCH_W-1:7]} + DAY_BIAS;

    always_ff @(posedge clk)
    begin
        v1_reg  <= v1_next;
        lo1_reg <= epoch_seconds[6:0];
    end

    // quotient estimate by 675, low by at most three
    assign qprod    = 49'(v1_reg[33:10]) * 49'(RECIP);
    assign qe2_next = qprod[47:24];

    always_ff @(posedge clk)
    begin
        qe2_reg <= qe2_next;
        v2_reg  <= v1_reg;
        lo2_reg <= lo1_reg;
    end

    assign rest     = v2_reg - 34'(qe2_reg) * 34'(DIV_675);
    assign re3_next = rest[11:0];

    always_ff @(posedge clk)
    begin
        re3_reg <= re3_next;
        qe3_reg <= qe2_reg;
        lo3_reg <= lo2_reg;
    end

    always_comb
    begin
        if (re3_reg >= 12'd2025)
        begin
            rfix = re3_reg - 12'd2025;
            qfix = qe3_reg + 24'd3;
        end
        else if (re3_reg >= 12'd1350)
        begin
            rfix = re3_reg - 12'd1350;
            qfix = qe3_reg + 24'd2;
        end
        else if (re3_reg >= 12'd675)
        begin
            rfix = re3_reg - 12'd675;
            qfix = qe3_reg + 24'd1;
        end
        else
        begin
            rfix = re3_reg;
            qfix = qe3_reg;
        end
        split_next.days = qfix;
        split_next.sod  = {rfix[9:0], lo3_reg};
    end

    always_ff @(posedge clk)
    begin
        split_reg <= split_next;
    end

    assign split = split_reg;

endmodule

// File: hw/rtl/e2c_clock.sv
// time of day and weekday pipeline, padded to the date pipeline latency
module e2c_clock
    import e2c_pkg::*;
(
    input  logic       clk,
    input  day_split_t split,
    output tod_t       tod
);

    localparam int unsigned PAD       = CIV_LAT - CLK_LAT;
    localparam int unsigned WD_CHUNKS = DAYS_W / 3;
    localparam logic [5:0]  WD_BIAS   = 6'd4;

    logic [32:0]       hprod;
    logic [HOUR_W-1:0] hour1_next;
    logic [HOUR_W-1:0] hour1_reg;
    logic [SOD_W-1:0]  sod1_reg;
    logic [5:0]        wsum1_next;
    logic [5:0]        wsum1_reg;

    logic [SOD_W-1:0]  rem_full;
    logic [11:0]       rem2_reg;
    logic [HOUR_W-1:0] hour2_reg;
    logic [3:0]        fold;
    logic [WDAY_W-1:0] wd2_next;
    logic [WDAY_W-1:0] wd2_reg;

    logic [24:0]       mprod;
    logic [MIN_W-1:0]  min3_next;
    logic [MIN_W-1:0]  min3_reg;
    logic [11:0]       rem3_reg;
    logic [HOUR_W-1:0] hour3_reg;
    logic [WDAY_W-1:0] wd3_reg;

    logic [11:0]       sec_full;
    tod_t              tod4_next;
    tod_t              tod4_reg;
    tod_t              pad_reg [PAD];

    assign hprod      = 33'(split.sod) * 33'd37283;
    assign hour1_next = hprod[31:27];

    // 8 is 1 mod 7, so summing octal digits keeps the residue
    always_comb
    begin
        wsum1_next = WD_BIAS;
        for (int i = 0; i < WD_CHUNKS; i++)
        begin
            wsum1_next = wsum1_next + 6'(split.days[3*i +: 3]);
        end
    end

    always_ff @(posedge clk)
    begin
        hour1_reg <= hour1_next;
        sod1_reg  <= split.sod;
        wsum1_reg <= wsum1_next;
    end

    assign rem_full = sod1_reg - 17'(hour1_reg) * 17'd3600;
    assign fold     = 4'(wsum1_reg[2:0]) + 4'(wsum1_reg[5:3]);

    always_comb
    begin
        if (fold >= 4'd14)
        begin
            wd2_next = 3'(fold - 4'd14);
        end
        else if (fold >= 4'd7)
        begin
            wd2_next = 3'(fold - 4'd7);
        end
        else
        begin
            wd2_next = fold[2:0];
        end
    end

    always_ff @(posedge clk)
    begin
        rem2_reg  <= rem_full[11:0];
        hour2_reg <= hour1_reg;
        wd2_reg   <= wd2_next;
    end

    assign mprod     = 25'(rem2_reg) * 25'd4370;
    assign min3_next = mprod[23:18];

    always_ff @(posedge clk)
    begin
        min3_reg  <= min3_next;
        rem3_reg  <= rem2_reg;
        hour3_reg <= hour2_reg;
        wd3_reg   <= wd2_reg;
    end

    assign sec_full = rem3_reg - 12'(min3_reg) * 12'd60;

    always_comb
    begin
        tod4_next.hour    = hour3_reg;
        tod4_next.minute  = min3_reg;
        tod4_next.second  = sec_full[5:0];
        tod4_next.weekday = wd3_reg;
    end

    always_ff @(posedge clk)
    begin
        tod4_reg   <= tod4_next;
        pad_reg[0] <= tod4_reg;
        for (int i = 1; i < PAD; i++)
        begin
            pad_reg[i] <= pad_reg[i-1];
        end
    end

    assign tod = pad_reg[PAD-1];

endmodule

// File: hw/rtl/e2c_civil.sv
// ten-stage conversion of a biased day count into year, month and day
module e2c_civil
    import e2c_pkg::*;
(
    input  logic              clk,
    input  logic [DAYS_W-1:0] days,
    output date_t             date
);

    localparam logic [23:0] ERA_BIAS = 24'd54335;
    localparam logic [16:0] ERA_RCP  = 17'd117592;
    localparam logic [17:0] ERA_DAYS = 18'd146097;
    localparam logic [17:0] ERA_LAST = 18'd146096;
    localparam logic [17:0] Y4_RCP   = 18'd183860;
    localparam logic [16:0] YR_BIAS  = 17'd15600;

    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] r;
        unique case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    logic [23:0] zz1_reg;

    logic [30:0] eprod;
    logic [6:0]  era2_reg;
    logic [23:0] zz2_reg;

    logic [23:0] doe_full;
    logic [18:0] doe3_reg;
    logic [6:0]  era3_reg;

    logic [17:0] doe4_next;
    logic [6:0]  era4_next;
    logic [17:0] doe4_reg;
    logic [6:0]  era4_reg;

    logic [35:0] aprod;
    logic [2:0]  b5_next;
    logic [6:0]  a5_reg;
    logic [2:0]  b5_reg;
    logic        c5_reg;
    logic [17:0] doe5_reg;
    logic [15:0] e400_5_reg;

    logic [17:0] n6_reg;
    logic [17:0] doe6_reg;
    logic [15:0] e400_6_reg;

    logic [35:0] yprod;
    logic [8:0]  yoe7_reg;
    logic [17:0] doe7_reg;
    logic [15:0] e400_7_reg;

    logic [1:0]  cent;
    logic [17:0] ystart;
    logic [17:0] doy_full;
    logic [16:0] ybase_full;
    logic [8:0]  doy8_reg;
    logic signed [YEAR_W-1:0] ybase8_reg;

    logic [10:0] mx;
    logic [23:0] mprod;
    logic [3:0]  mp9_reg;
    logic [8:0]  doy9_reg;
    logic signed [YEAR_W-1:0] ybase9_reg;

    logic [8:0]  dd_full;
    date_t       date_next;
    date_t       date_reg;

    always_ff @(posedge clk)
    begin
        zz1_reg <= days + ERA_BIAS;
    end

    // 400-year era estimate, low by at most one
    assign eprod = 31'(zz1_reg[23:10]) * 31'(ERA_RCP);

    always_ff @(posedge clk)
    begin
        era2_reg <= eprod[30:24];
        zz2_reg  <= zz1_reg;
    end

    assign doe_full = zz2_reg - 24'(era2_reg) * 24'(ERA_DAYS);

    always_ff @(posedge clk)
    begin
        doe3_reg <= doe_full[18:0];
        era3_reg <= era2_reg;
    end

    always_comb
    begin
        if (doe3_reg >= 19'(ERA_DAYS))
        begin
            doe4_next = 18'(doe3_reg - 19'(ERA_DAYS));
            era4_next = era3_reg + 7'd1;
        end
        else
        begin
            doe4_next = doe3_reg[17:0];
            era4_next = era3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        doe4_reg <= doe4_next;
        era4_reg <= era4_next;
    end

    assign aprod   = 36'(doe4_reg) * 36'(Y4_RCP);
    assign b5_next = 3'(doe4_reg >= 18'd36524) + 3'(doe4_reg >= 18'd73048)
                   + 3'(doe4_reg >= 18'd109572) + 3'(doe4_reg >= ERA_LAST);

    always_ff @(posedge clk)
    begin
        a5_reg     <= aprod[34:28];
        b5_reg     <= b5_next;
        c5_reg     <= (doe4_reg >= ERA_LAST);
        doe5_reg   <= doe4_reg;
        e400_5_reg <= 16'(era4_reg) * 16'd400;
    end

    always_ff @(posedge clk)
    begin
        n6_reg     <= doe5_reg - 18'(a5_reg) + 18'(b5_reg) - 18'(c5_reg);
        doe6_reg   <= doe5_reg;
        e400_6_reg <= e400_5_reg;
    end

    // year of era: n / 365
    assign yprod = 36'(n6_reg) * 36'(Y4_RCP);

    always_ff @(posedge clk)
    begin
        yoe7_reg   <= yprod[34:26];
        doe7_reg   <= doe6_reg;
        e400_7_reg <= e400_6_reg;
    end

    assign cent       = 2'(yoe7_reg >= 9'd100) + 2'(yoe7_reg >= 9'd200)
                      + 2'(yoe7_reg >= 9'd300);
    assign ystart     = 18'(yoe7_reg) * 18'd365 + 18'(yoe7_reg[8:2]) - 18'(cent);
    assign doy_full   = doe7_reg - ystart;
    assign ybase_full = 17'(yoe7_reg) + 17'(e400_7_reg) - YR_BIAS;

    always_ff @(posedge clk)
    begin
        doy8_reg   <= doy_full[8:0];
        ybase8_reg <= ybase_full[YEAR_W-1:0];
    end

    // month index counted from march
    assign mx    = 11'(doy8_reg) * 11'd5 + 11'd2;
    assign mprod = 24'(mx) * 24'd6854;

    always_ff @(posedge clk)
    begin
        mp9_reg    <= mprod[23:20];
        doy9_reg   <= doy8_reg;
        ybase9_reg <= ybase8_reg;
    end

    assign dd_full = doy9_reg - month_start(mp9_reg) + 9'd1;

    always_comb
    begin
        date_next.day = dd_full[4:0];
        if (mp9_reg >= 4'd10)
        begin
            date_next.month = mp9_reg - 4'd9;
            date_next.year  = ybase9_reg + 16'sd1;
        end
        else
        begin
            date_next.month = mp9_reg + 4'd3;
            date_next.year  = ybase9_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        date_reg <= date_next;
    end

    assign date = date_reg;

endmodule

// File: hw/rtl/epoch_to_calendar_converter.sv
// top level of the epoch seconds to calendar date and time converter
//
// command channel: a beat is taken at each rising edge with start high and busy
// low; busy is always low, so a new timestamp can enter on every cycle.
// result channel: done is high for one cycle with year, month, day, hour,
// minute, second and weekday valid in that cycle; the receiver takes it then.
// pipeline: 4 stages of day/second split, then 10 stages of date conversion,
// with the time-of-day path padded to match.
// throughput: one beat per cycle, fixed by the fully pipelined datapath; every
// multiplier stage holds at most two constant multiplies followed by a register.
// reset: rst_n clears the valid line at once; beats in flight are dropped and
// done stays low until new beats come through. datapath registers keep running.
// results come out in the order the beats went in and are never held back.
module epoch_to_calendar_converter
    import e2c_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [EPOCH_W-1:0] epoch_seconds,
    output logic                      done,
    output logic signed [YEAR_W-1:0]  year,
    output logic [MONTH_W-1:0]        month,
    output logic [DAY_W-1:0]          day,
    output logic [HOUR_W-1:0]         hour,
    output logic [MIN_W-1:0]          minute,
    output logic [SEC_W-1:0]          second,
    output logic [WDAY_W-1:0]         weekday
);

    logic               accept;
    logic [E2C_LAT-1:0] vld_next;
    logic [E2C_LAT-1:0] vld_reg;
    day_split_t         split;
    tod_t               tod;
    date_t              date;

    assign busy     = 1'b0;
    assign accept   = start & ~busy;
    assign vld_next = {vld_reg[E2C_LAT-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    e2c_day_split u_split
    (
        .clk           (clk),
        .epoch_seconds (epoch_seconds),
        .split         (split)
    );

    e2c_clock u_clock
    (
        .clk   (clk),
        .split (split),
        .tod   (tod)
    );

    e2c_civil u_civil
    (
        .clk  (clk),
        .days (split.days),
        .date (date)
    );

    assign done    = vld_reg[E2C_LAT-1];
    assign year    = date.year;
    assign month   = date.month;
    assign day     = date.day;
    assign hour    = tod.hour;
    assign minute  = tod.minute;
    assign second  = tod.second;
    assign weekday = tod.weekday;

endmodule

// File: hw/rtl/e2c_checker.sv
// port-level checker for the converter and its bind to the top level
module e2c_checker
    import e2c_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic signed [EPOCH_W-1:0] epoch_seconds,
    input logic                      done,
    input logic signed [YEAR_W-1:0]  year,
    input logic [MONTH_W-1:0]        month,
    input logic [DAY_W-1:0]          day,
    input logic [HOUR_W-1:0]         hour,
    input logic [MIN_W-1:0]          minute,
    input logic [SEC_W-1:0]          second,
    input logic [WDAY_W-1:0]         weekday
);

    // every accepted beat comes out after the fixed latency
    a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##E2C_LAT done)
        else $error("accepted beat did not produce a result");

    // no result without a matching accepted beat
    a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, E2C_LAT))
        else $error("result without an accepted beat");

    a_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (month >= 4'd1 && month <= 4'd12 && day >= 5'd1 && hour <= 5'd23
                  && minute <= 6'd59 && second <= 6'd59 && weekday <= 3'd6))
        else $error("result field out of range");

    // same calendar date on back-to-back results means same weekday
    a_wday: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(done) && year == $past(year) && month == $past(month)
         && day == $past(day)) |-> (weekday == $past(weekday)))
        else $error("weekday differs for the same date");

endmodule

bind epoch_to_calendar_converter e2c_checker u_e2c_checker (.*);

// File: test/epoch_to_calendar_checker.sv
// watches the converter ports, predicts the calendar fields of each beat and compares
module epoch_to_calendar_checker
    import e2c_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic signed [EPOCH_W-1:0] epoch_seconds,
    input  logic                      done,
    input  logic signed [YEAR_W-1:0]  year,
    input  logic [MONTH_W-1:0]        month,
    input  logic [DAY_W-1:0]          day,
    input  logic [HOUR_W-1:0]         hour,
    input  logic [MIN_W-1:0]          minute,
    input  logic [SEC_W-1:0]          second,
    input  logic [WDAY_W-1:0]         weekday,
    output int                        mismatches,
    output int                        pending,
    output int                        matched
);

    localparam longint SECS_PER_DAY  = 86400;
    localparam longint SHIFT_TO_MAR1 = 719468;
    localparam longint ERA_DAYS      = 146097;
    localparam longint ERA_LAST      = 146096;
    localparam longint QUAD_LAST     = 1460;
    localparam longint CENT_LAST     = 36524;
    localparam int     DEPTH         = 64;

    typedef struct packed {
        logic signed [YEAR_W-1:0] year;
        logic [MONTH_W-1:0]       month;
        logic [DAY_W-1:0]         day;
        logic [HOUR_W-1:0]        hour;
        logic [MIN_W-1:0]         minute;
        logic [SEC_W-1:0]         second;
        logic [WDAY_W-1:0]        weekday;
    } calendar_t;

    // predicted beats waiting for their result, kept in a ring
    calendar_t  expected_dates [DEPTH];
    logic [5:0] wr_ptr;
    logic [5:0] rd_ptr;
    int         fill;

    function automatic calendar_t to_calendar(input logic signed [EPOCH_W-1:0] stamp);
        longint    secs;
        longint    days;
        longint    sod;
        longint    z;
        longint    era;
        longint    doe;
        longint    yoe;
        longint    doy;
        longint    mp;
        longint    mon;
        longint    dom;
        longint    yr;
        longint    wd;
        calendar_t c;
        secs = stamp;
        days = secs / SECS_PER_DAY;
        sod  = secs % SECS_PER_DAY;
        // floor division: negative time of day belongs to the previous day
        if (sod < 0)
        begin
            sod  = sod + SECS_PER_DAY;
            days = days - 1;
        end
        z   = days + SHIFT_TO_MAR1;
        era = ((z >= 0) ? z : z - ERA_LAST) / ERA_DAYS;
        doe = z - era * ERA_DAYS;
        yoe = (doe - doe / QUAD_LAST + doe / CENT_LAST - doe / ERA_LAST) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp  = (5 * doy + 2) / 153;
        dom = doy - (153 * mp + 2) / 5 + 1;
        mon = (mp < 10) ? mp + 3 : mp - 9;
        yr  = yoe + era * 400 + ((mon <= 2) ? 1 : 0);
        // day zero was a thursday
        wd  = ((days % 7) + 11) % 7;
        c.year    = YEAR_W'(yr);
        c.month   = MONTH_W'(mon);
        c.day     = DAY_W'(dom);
        c.hour    = HOUR_W'(sod / 3600);
        c.minute  = MIN_W'((sod / 60) % 60);
        c.second  = SEC_W'(sod % 60);
        c.weekday = WDAY_W'(wd);
        return c;
    endfunction

    task automatic flag_field(input string field, input longint want, input longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        calendar_t want;
        int        errs_before;
        if (!rst_n)
        begin
            wr_ptr     = '0;
            rd_ptr     = '0;
            fill       = 0;
            mismatches = 0;
            pending    = 0;
            matched    = 0;
        end
        else
        begin
            if (done)
            begin
                if (fill == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, actual %0d-%0d-%0d",
                             $time, year, month, day);
                    mismatches++;
                end
                else
                begin
                    want        = expected_dates[rd_ptr];
                    rd_ptr      = rd_ptr + 6'd1;
                    fill        = fill - 1;
                    errs_before = mismatches;
                    flag_field("year", want.year, year);
                    flag_field("month", want.month, month);
                    flag_field("day", want.day, day);
                    flag_field("hour", want.hour, hour);
                    flag_field("minute", want.minute, minute);
                    flag_field("second", want.second, second);
                    flag_field("weekday", want.weekday, weekday);
                    if (mismatches == errs_before)
                        matched++;
                end
            end
            if (start && !busy)
            begin
                if (fill == DEPTH)
                begin
                    $display("%0t: too many beats in flight, expected at most %0d, actual %0d",
                             $time, DEPTH, fill + 1);
                    mismatches++;
                end
                else
                begin
                    expected_dates[wr_ptr] = to_calendar(epoch_seconds);
                    wr_ptr                 = wr_ptr + 6'd1;
                    fill                   = fill + 1;
                end
            end
            pending = fill;
        end
    end

endmodule

// File: test/epoch_to_calendar_converter_tb.sv
// testbench top: drives timestamps into the converter and reports the verdict
module epoch_to_calendar_converter_tb;
    import e2c_pkg::*;

    localparam int     RANDOM_BEATS = 2000;
    localparam longint EPOCH_MAX    = 64'sd549755813887;
    localparam longint EPOCH_MIN    = -64'sd549755813888;
    localparam longint DAY_SECS     = 86400;
    localparam longint ERA_LEN      = 146097;
    localparam longint MAR1_SHIFT   = 719468;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic signed [EPOCH_W-1:0] epoch_seconds;
    logic                      done;
    logic signed [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0]        month;
    logic [DAY_W-1:0]          day;
    logic [HOUR_W-1:0]         hour;
    logic [MIN_W-1:0]          minute;
    logic [SEC_W-1:0]          second;
    logic [WDAY_W-1:0]         weekday;
    int                        mismatches;
    int                        pending;
    int                        matched;
    int                        beats_sent;
    int                        negative_sent;

    epoch_to_calendar_converter u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .epoch_seconds (epoch_seconds),
        .done          (done),
        .year          (year),
        .month         (month),
        .day           (day),
        .hour          (hour),
        .minute        (minute),
        .second        (second),
        .weekday       (weekday)
    );

    epoch_to_calendar_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .epoch_seconds (epoch_seconds),
        .done          (done),
        .year          (year),
        .month         (month),
        .day           (day),
        .hour          (hour),
        .minute        (minute),
        .second        (second),
        .weekday       (weekday),
        .mismatches    (mismatches),
        .pending       (pending),
        .matched       (matched)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("epoch_to_calendar_converter verification failed");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_stamp(input longint stamp);
        start         <= 1'b1;
        epoch_seconds <= stamp[EPOCH_W-1:0];
        do
            @(posedge clk);
        while (busy);
        beats_sent++;
        if (stamp < 0)
            negative_sent++;
        @(negedge clk);
    endtask

    function automatic longint pick_stamp();
        longint t;
        longint d;
        t = longint'({$urandom, $urandom});
        case ($urandom_range(0, 9))
            0, 1, 2:
                t = longint'(signed'(t[EPOCH_W-1:0]));
            3, 4:
            begin
                // around a midnight
                d = longint'($urandom_range(0, 12724000)) - 6362000;
                t = d * DAY_SECS + longint'($urandom_range(0, 2)) - 1;
            end
            5:
            begin
                // around the first of march that opens a 400-year era
                d = (longint'($urandom_range(0, 86)) - 38) * ERA_LEN - MAR1_SHIFT
                    + longint'($urandom_range(0, 2)) - 1;
                t = d * DAY_SECS + longint'($urandom_range(0, 86399));
            end
            6, 7:
                t = longint'(signed'(t[32:0]));
            default:
                t = longint'($urandom_range(0, 20000000)) - 10000000;
        endcase
        if (t > EPOCH_MAX || t < EPOCH_MIN)
            t = longint'(signed'(t[EPOCH_W-1:0]));
        return t;
    endfunction

    longint directed_stamps[] = '{
        0, -1, 1, 86399, 86400, -86400, -86401,
        EPOCH_MAX, EPOCH_MIN, EPOCH_MAX - 86399, EPOCH_MIN + 86401,
        951782400, 951868800, 951868799,
        -2203891200, -2203977600,
        4107456000, 4107542400,
        -62162035200, -62162035201, -62167219200, -62167219201,
        2147483647, 2147483648, 4294967295
    };

    initial
    begin
        int burst;
        int gap;
        int sent_random;
        rst_n         <= 1'b0;
        start         <= 1'b0;
        epoch_seconds <= '0;
        beats_sent    = 0;
        negative_sent = 0;
        sent_random   = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_stamps[i])
            send_stamp(directed_stamps[i]);

        while (sent_random < RANDOM_BEATS)
        begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent_random < RANDOM_BEATS; k++)
            begin
                send_stamp(pick_stamp());
                sent_random++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (E2C_LAT + 8) @(posedge clk);

        $display("sent %0d timestamps (%0d before 1970, %0d directed), %0d results matched",
                 beats_sent, negative_sent, directed_stamps.size(), matched);
        if (mismatches == 0 && pending == 0)
            $display("epoch_to_calendar_converter verification clean");
        else
            $display("epoch_to_calendar_converter verification failed");
        $finish;
    end

endmodule
